>>> sv/touch_press_classifier_core_defines.svh
// Assertion macros shared by the touch press classifier.
`ifndef TOUCH_PRESS_CLASSIFIER_CORE_DEFINES_SVH
`define TOUCH_PRESS_CLASSIFIER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tpc_pkg.sv
package tpc_pkg;

  // Event codes carried on the result word.
  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_t;

  // Configuration port widths and register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int THR_W       = 8;
  localparam int CFG_TICK_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TICKS   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PRESS_TICKS    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_TICKS      = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]      RST_DEBOUNCE_THRESHOLD = 8'd5;
  localparam logic [CFG_TICK_W-1:0] RST_LONG_PRESS_TICKS   = 16'd150;
  localparam logic [CFG_TICK_W-1:0] RST_MIN_PRESS_TICKS    = 16'd8;
  localparam logic [CFG_TICK_W-1:0] RST_LOCKOUT_TICKS      = 16'd25;

  // Current configuration as seen by the classifier.
  typedef struct packed {
    logic [THR_W-1:0]      debounce_threshold;
    logic [CFG_TICK_W-1:0] long_press_ticks;
    logic [CFG_TICK_W-1:0] min_press_ticks;
    logic [CFG_TICK_W-1:0] lockout_ticks;
  } cfg_t;

  // One result word.
  typedef struct packed {
    evt_t event_kind;
    logic pressed;
  } result_t;

endpackage

>>> sv/tpc_cfg_regs.sv
module tpc_cfg_regs
  import tpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; indexes past the last register are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_THRESHOLD: cfg_nxt.debounce_threshold = cfg_wdata[THR_W-1:0];
        CFG_LONG_PRESS_TICKS:   cfg_nxt.long_press_ticks   = cfg_wdata[CFG_TICK_W-1:0];
        CFG_MIN_PRESS_TICKS:    cfg_nxt.min_press_ticks    = cfg_wdata[CFG_TICK_W-1:0];
        CFG_LOCKOUT_TICKS:      cfg_nxt.lockout_ticks      = cfg_wdata[CFG_TICK_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_threshold <= RST_DEBOUNCE_THRESHOLD;
      cfg_r.long_press_ticks   <= RST_LONG_PRESS_TICKS;
      cfg_r.min_press_ticks    <= RST_MIN_PRESS_TICKS;
      cfg_r.lockout_ticks      <= RST_LOCKOUT_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/tpc_in_stage.sv
module tpc_in_stage
  import tpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_raw_level,
  input  logic advance,
  output logic stg_valid,
  output logic stg_raw_level
);

  logic valid_r;
  logic valid_nxt;
  logic raw_r;

  // The stage takes a new word whenever it is empty or moving on this cycle.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_valid || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_r <= in_raw_level;
    end
  end

  assign stg_valid     = valid_r;
  assign stg_raw_level = raw_r;

endmodule

>>> sv/tpc_classify.sv
module tpc_classify
  import tpc_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    advance,
  input  logic    raw_level,
  output result_t result
);

  localparam int TW = TICK_COUNT_WIDTH;
  localparam int CW = (TW > CFG_TICK_W) ? TW : CFG_TICK_W;
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  logic [THR_W-1:0] integ_r, integ_nxt;
  logic             stable_r, stable_nxt;
  logic [TW-1:0]    held_r, held_nxt;
  logic [TW-1:0]    since_r, since_nxt;
  logic             long_done_r, long_done_nxt;

  logic [THR_W-1:0] thr;
  logic [TW-1:0]    held_inc;
  logic [TW-1:0]    since_inc;
  logic             press;
  logic             release_ev;
  logic             short_ev;
  logic             long_ev;
  logic             ld_after_press;

  // A threshold of zero behaves as one.
  assign thr = (cfg.debounce_threshold == '0) ? THR_W'(1) : cfg.debounce_threshold;

  // Saturating tick counters.
  assign since_inc = (since_r == TICK_MAX) ? since_r : since_r + TW'(1);
  assign held_inc  = (stable_r && held_r != TICK_MAX) ? held_r + TW'(1) : held_r;

  // Integrator moves one step toward the reading.
  always_comb begin
    integ_nxt = integ_r;
    if (raw_level) begin
      if (integ_r < thr) begin
        integ_nxt = integ_r + THR_W'(1);
      end
    end else if (integ_r != '0) begin
      integ_nxt = integ_r - THR_W'(1);
    end
  end

  // Press and release decisions, then the short and long events.
  always_comb begin
    press          = !stable_r && (integ_nxt >= thr);
    release_ev     = stable_r && (integ_nxt == '0);
    stable_nxt     = press ? 1'b1 : (release_ev ? 1'b0 : stable_r);
    held_nxt       = press ? '0 : held_inc;
    ld_after_press = press ? 1'b0 : long_done_r;
    short_ev       = release_ev && !long_done_r
                     && (CW'(held_inc) >= CW'(cfg.min_press_ticks))
                     && (CW'(since_inc) >= CW'(cfg.lockout_ticks));
    since_nxt      = short_ev ? '0 : since_inc;
    long_ev        = stable_nxt && !ld_after_press
                     && (CW'(held_nxt) >= CW'(cfg.long_press_ticks));
    long_done_nxt  = ld_after_press || long_ev;
  end

  always_comb begin
    result.pressed = stable_nxt;
    if (long_ev) begin
      result.event_kind = EVT_LONG;
    end else if (short_ev) begin
      result.event_kind = EVT_SHORT;
    end else begin
      result.event_kind = EVT_NONE;
    end
  end

  // State moves only when a word passes to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      stable_r    <= 1'b0;
      held_r      <= '0;
      since_r     <= '0;
      long_done_r <= 1'b0;
    end else if (advance) begin
      integ_r     <= integ_nxt;
      stable_r    <= stable_nxt;
      held_r      <= held_nxt;
      since_r     <= since_nxt;
      long_done_r <= long_done_nxt;
    end
  end

endmodule

>>> sv/tpc_out_reg.sv
module tpc_out_reg
  import tpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       stg_valid,
  input  result_t    result,
  output logic       advance,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic       out_pressed
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // A word moves in when the register is empty or being drained.
  assign advance   = stg_valid && (!valid_r || out_ready);
  assign valid_nxt = advance || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_valid      = valid_r;
  assign out_event_kind = res_r.event_kind;
  assign out_pressed    = res_r.pressed;

endmodule

>>> sv/touch_press_classifier_core.sv
// Integrating touch debounce with short and long press events. One raw touch
// level is taken per cycle and each gives exactly one result word (event kind
// and debounced state). A word is held in the input register and its result
// is then registered in the output register; the sustained rate is one word
// per cycle, and the only thing that slows it is the consumer holding
// out_ready low. All classifier state lives in single registers updated as
// each word moves into the output register. Configuration should be written
// only while idle.
`include "touch_press_classifier_core_defines.svh"

module touch_press_classifier_core
  import tpc_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_raw_level,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_event_kind,
  output logic                   out_pressed,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  logic    advance;
  logic    stg_valid;
  logic    stg_raw_level;
  result_t result;

  tpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  tpc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_raw_level (in_raw_level),
    .advance      (advance),
    .stg_valid    (stg_valid),
    .stg_raw_level(stg_raw_level)
  );

  tpc_classify #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .advance  (advance),
    .raw_level(stg_raw_level),
    .result   (result)
  );

  tpc_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .stg_valid     (stg_valid),
    .result        (result),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_pressed   (out_pressed)
  );

  // A long event is only reported while the touch is still held.
  `TPC_ASSERT_SAME(a_long_held, clk, rst_n, out_valid && out_event_kind == EVT_LONG, out_pressed, "long event without press")
  // A short event is only reported on the release word.
  `TPC_ASSERT_SAME(a_short_released, clk, rst_n, out_valid && out_event_kind == EVT_SHORT, !out_pressed, "short event while pressed")
  // A word moved on always shows up in the output register.
  `TPC_ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid, "advanced word lost")
  // Back-pressure on the input only comes from a full input register behind a full output register that is not drained.
  `TPC_ASSERT_SAME(a_ready_stall, clk, rst_n, !in_ready, stg_valid && out_valid && !out_ready, "input stalled without cause")

endmodule
